>>> rtl/tdjs_pkg.sv
// Shared types, codes and constants of the tick-driven job scheduler.
package tdjs_pkg;

  // Table depth default and fixed field widths
  localparam int SLOTS_DEF  = 16;
  localparam int PID_W      = 8;
  localparam int TIME_IN_W  = 16;
  localparam int PRIO_W     = 8;
  localparam int NOW_W      = 32;
  localparam int STATUS_W   = 3;
  localparam int JOBS_W     = 5;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_DATA_W = 2;
  localparam int ENTRY_W    = PID_W + 2 * TIME_IN_W + PRIO_W;

  localparam logic [NOW_W-1:0] TIME_MAX = {NOW_W{1'b1}};

  // Request kinds carried in tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Configuration register indexes
  localparam logic CFG_PREEMPT = 1'b0;
  localparam logic CFG_KEY     = 1'b1;

  // Selection key codes
  localparam logic [1:0] KEY_REM  = 2'd0;
  localparam logic [1:0] KEY_PRIO = 2'd1;
  localparam logic [1:0] KEY_ARR  = 2'd2;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    RS_LOADED    = 3'd0,
    RS_FULL      = 3'd1,
    RS_ZERO      = 3'd2,
    RS_RAN       = 3'd3,
    RS_IDLE      = 3'd4,
    RS_ALL_DONE  = 3'd5
  } rstat_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic best_clr;
    logic idx_clr;
    logic idx_inc;
    logic load_step;
    logic rd_scan;
    logic rd_cur;
    logic commit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_tick;
    logic burst_zero;
    logic empty;
    logic use_cur;
    logic idx_last;
    logic free_hit;
    logic out_busy;
  } stat_t;

endpackage

>>> rtl/tick_driven_job_scheduler_core.sv
// Top level of the tick-driven job scheduler: controller and datapath.
// Job table of SLOTS entries held in a single-port-read memory. A load transaction searches
// the valid bits for the lowest free slot, one slot per cycle. A tick transaction that must
// pick a job reads the table one slot per cycle through the memory read port; a non-preemptive
// tick that continues the running job reads only its entry; a tick on an empty table or a
// zero-burst load reads no entry. One transaction is worked on at a time; the next is accepted
// while the previous result still waits in the output register. Configuration must be written
// by the user only while the block is idle; the block itself does not enforce this.
module tick_driven_job_scheduler_core #(
  parameter int SLOTS = tdjs_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [tdjs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic                                in_tuser,   // req_type
  input  logic [tdjs_pkg::IN_DATA_W-1:0]      in_tdata,   // proc_pid, arrival_time, burst_time, prio_level
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tdjs_pkg::STATUS_W-1:0]       out_tuser,  // status
  output logic [tdjs_pkg::OUT_DATA_W-1:0]     out_tdata   // run_pid, tick_time, job_finished, jobs_left, pad
);
  import tdjs_pkg::*;

  cmd_t  cmd;
  stat_t st;

  tdjs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  tdjs_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

>>> rtl/tdjs_ctrl.sv
// Controller state machine of the job scheduler: sequences load and tick transactions.
module tdjs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  tdjs_pkg::stat_t st,
  output tdjs_pkg::cmd_t  cmd
);
  import tdjs_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture  = 1'b1;
          cmd.best_clr = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_nxt    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!st.is_tick) begin
          state_nxt = st.burst_zero ? S_COMMIT : S_LOAD;
        end else if (st.empty) begin
          state_nxt = S_COMMIT;
        end else if (st.use_cur) begin
          // running job keeps the CPU: fetch its entry only
          cmd.rd_cur = 1'b1;
          state_nxt  = S_DRAIN;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_LOAD: begin
        // free-slot search, lowest slot first
        cmd.load_step = 1'b1;
        if (st.free_hit || st.idx_last) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.rd_scan = 1'b1;
        cmd.idx_inc = 1'b1;
        if (st.idx_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read word is compared in this cycle
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!st.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A result is only committed from the commit state
  a_commit_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (state_r == S_COMMIT))
    else $error("commit issued outside commit state");

  // After a commit the controller is ready for the next transaction
  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> in_tready)
    else $error("not ready after commit");

  // A captured transaction is never followed directly by another capture
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !in_tready)
    else $error("second transaction taken while busy");

endmodule

>>> rtl/tdjs_dp.sv
// Datapath of the job scheduler: job table memory, scan compare, time and result registers.
module tdjs_dp #(
  parameter int SLOTS = tdjs_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [tdjs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_tuser,
  input  logic [tdjs_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tdjs_pkg::STATUS_W-1:0]       out_tuser,
  output logic [tdjs_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  tdjs_pkg::cmd_t                      cmd,
  output tdjs_pkg::stat_t                     st
);
  import tdjs_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // Configuration
  logic       preempt_r;
  logic [1:0] key_sel_r;

  // Captured transaction
  logic                 req_r;
  logic [PID_W-1:0]     in_pid_r;
  logic [TIME_IN_W-1:0] in_arr_r;
  logic [TIME_IN_W-1:0] in_burst_r;
  logic [PRIO_W-1:0]    in_prio_r;

  // Table state
  logic [ENTRY_W-1:0]   mem [SLOTS];
  logic [SLOTS-1:0]     valid_r, valid_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [NOW_W-1:0]     now_r, now_nxt;
  logic [SW-1:0]        cur_slot_r, cur_slot_nxt;
  logic                 cur_active_r, cur_active_nxt;

  // Scan
  logic [SW-1:0]        idx_r;
  logic [SW-1:0]        rd_addr;
  logic [ENTRY_W-1:0]   rd_data_r;
  logic [SW-1:0]        rd_idx_r;
  logic                 rd_pend_r;
  logic                 rd_take_r;

  // Best candidate
  logic                 found_r;
  logic [SW-1:0]        best_idx_r;
  logic [PID_W-1:0]     best_pid_r;
  logic [TIME_IN_W-1:0] best_arr_r;
  logic [TIME_IN_W-1:0] best_rem_r;
  logic [PRIO_W-1:0]    best_prio_r;
  logic [TIME_IN_W-1:0] best_key_r;

  // Read word fields
  logic [PID_W-1:0]     rd_pid;
  logic [TIME_IN_W-1:0] rd_arr;
  logic [TIME_IN_W-1:0] rd_rem;
  logic [PRIO_W-1:0]    rd_prio;
  logic [TIME_IN_W-1:0] rd_key;
  logic                 rd_cand;
  logic                 rd_better;

  // Commit
  logic                 wr_en;
  logic [ENTRY_W-1:0]   wr_data;
  logic [TIME_IN_W-1:0] rem_dec;
  rstat_t               res_status;
  logic [PID_W-1:0]     res_pid;
  logic                 res_fin;
  logic [CW+JOBS_W-1:0] cnt_ext;

  // Result registers
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [PID_W-1:0]     out_pid_r;
  logic [NOW_W-1:0]     out_time_r;
  logic                 out_fin_r;
  logic [JOBS_W-1:0]    out_jobs_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preempt_r <= 1'b0;
      key_sel_r <= KEY_REM;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PREEMPT: preempt_r <= cfg_wdata[0];
        CFG_KEY:     key_sel_r <= cfg_wdata[1:0];
        default:     preempt_r <= preempt_r;
      endcase
    end
  end

  // Capture of the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r      <= in_tuser;
      in_pid_r   <= in_tdata[7:0];
      in_arr_r   <= in_tdata[23:8];
      in_burst_r <= in_tdata[39:24];
      in_prio_r  <= in_tdata[47:40];
    end
  end

  // Scan index
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + SW'(1);
    end
  end

  // Table memory: one write and one registered read per cycle
  assign rd_addr = cmd.rd_cur ? cur_slot_r : idx_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[best_idx_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_scan || cmd.rd_cur) begin
      rd_data_r <= mem[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      rd_take_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_scan || cmd.rd_cur;
      rd_take_r <= cmd.rd_cur;
    end
  end

  // Entry layout: pid lowest, then arrival, remaining, priority
  assign rd_pid  = rd_data_r[PID_W-1:0];
  assign rd_arr  = rd_data_r[PID_W +: TIME_IN_W];
  assign rd_rem  = rd_data_r[PID_W+TIME_IN_W +: TIME_IN_W];
  assign rd_prio = rd_data_r[PID_W+2*TIME_IN_W +: PRIO_W];

  // Key of the word just read
  always_comb begin
    case (key_sel_r)
      KEY_REM:  rd_key = rd_rem;
      KEY_PRIO: rd_key = {{(TIME_IN_W-PRIO_W){1'b0}}, rd_prio};
      default:  rd_key = rd_arr;
    endcase
  end

  // Arrived job, strictly better key or earlier arrival on a tie
  assign rd_cand   = valid_r[rd_idx_r] && ({{(NOW_W-TIME_IN_W){1'b0}}, rd_arr} <= now_r);
  assign rd_better = !found_r || (rd_key < best_key_r) ||
                     ((rd_key == best_key_r) && (rd_arr < best_arr_r));

  // Best candidate tracking; load search reuses found and slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.best_clr) begin
      found_r <= 1'b0;
    end else if (cmd.load_step && !valid_r[idx_r] && !found_r) begin
      found_r <= 1'b1;
    end else if (rd_pend_r && (rd_take_r || (rd_cand && rd_better))) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_step && !valid_r[idx_r] && !found_r) begin
      best_idx_r <= idx_r;
    end else if (rd_pend_r && (rd_take_r || (rd_cand && rd_better))) begin
      best_idx_r  <= rd_idx_r;
      best_pid_r  <= rd_pid;
      best_arr_r  <= rd_arr;
      best_rem_r  <= rd_rem;
      best_prio_r <= rd_prio;
      best_key_r  <= rd_key;
    end
  end

  // Commit: table update, time advance and result
  assign rem_dec = best_rem_r - TIME_IN_W'(1);

  always_comb begin
    wr_en          = 1'b0;
    wr_data        = {best_prio_r, rem_dec, best_arr_r, best_pid_r};
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    now_nxt        = now_r;
    cur_slot_nxt   = cur_slot_r;
    cur_active_nxt = cur_active_r;
    res_status     = RS_IDLE;
    res_pid        = '0;
    res_fin        = 1'b0;
    if (req_r == REQ_LOAD) begin
      if (in_burst_r == '0) begin
        res_status = RS_ZERO;
      end else if (!found_r) begin
        res_status = RS_FULL;
      end else begin
        res_status            = RS_LOADED;
        wr_en                 = cmd.commit;
        wr_data               = {in_prio_r, in_burst_r, in_arr_r, in_pid_r};
        valid_nxt[best_idx_r] = 1'b1;
        cnt_nxt               = cnt_r + CW'(1);
      end
    end else if (cnt_r == '0) begin
      res_status     = RS_ALL_DONE;
      cur_active_nxt = 1'b0;
    end else begin
      if (found_r) begin
        res_status = RS_RAN;
        res_pid    = best_pid_r;
        wr_en      = cmd.commit;
        if (rem_dec == '0) begin
          valid_nxt[best_idx_r] = 1'b0;
          cnt_nxt               = cnt_r - CW'(1);
          res_fin               = 1'b1;
          cur_active_nxt        = 1'b0;
        end else begin
          cur_active_nxt = 1'b1;
          cur_slot_nxt   = best_idx_r;
        end
      end else begin
        res_status     = RS_IDLE;
        cur_active_nxt = 1'b0;
      end
      if (now_r != TIME_MAX) begin
        now_nxt = now_r + NOW_W'(1);
      end
    end
  end

  assign cnt_ext = {{JOBS_W{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      cnt_r        <= '0;
      now_r        <= '0;
      cur_slot_r   <= '0;
      cur_active_r <= 1'b0;
    end else if (cmd.commit) begin
      valid_r      <= valid_nxt;
      cnt_r        <= cnt_nxt;
      now_r        <= now_nxt;
      cur_slot_r   <= cur_slot_nxt;
      cur_active_r <= cur_active_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_pid_r    <= res_pid;
      out_time_r   <= now_r;
      out_fin_r    <= res_fin;
      out_jobs_r   <= cnt_ext[JOBS_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_DATA_W-PID_W-NOW_W-1-JOBS_W){1'b0}},
                       out_jobs_r, out_fin_r, out_time_r, out_pid_r};

  // Status to the controller
  assign st.is_tick    = (req_r == REQ_TICK);
  assign st.burst_zero = (in_burst_r == '0);
  assign st.empty      = (cnt_r == '0);
  assign st.use_cur    = !preempt_r && cur_active_r && valid_r[cur_slot_r];
  assign st.idx_last   = (idx_r == SW'(SLOTS - 1));
  assign st.free_hit   = !valid_r[idx_r];
  assign st.out_busy   = out_valid_r && !out_tready;

  // Held-job count tracks the valid bits
  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CW'($countones(valid_r)))
    else $error("job count differs from valid bits");

  // An active running job is always a held job
  a_cur_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cur_active_r |-> valid_r[cur_slot_r])
    else $error("running job not in table");

  // Time never moves backwards
  a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (now_r >= $past(now_r)))
    else $error("time decreased");

  // The table is never written while a result still waits
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && !out_tready))
    else $error("result overwritten");

endmodule

>>> sim/tb_tick_driven_job_scheduler_core.sv
// Self-checking testbench for the tick-driven job scheduler core.
`timescale 1ns / 100ps

module tb_tick_driven_job_scheduler_core;
  import tdjs_pkg::*;

  localparam int NSLOT       = SLOTS_DEF;
  localparam int SETTLE      = NSLOT + 8;   // longest transaction plus margin
  localparam int STALL_LIMIT = 4000;        // cycles with no transaction at all
  localparam int HOLD_AFTER  = 120;         // results before the long output hold
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 60;
  localparam int MAX_REPORT  = 10;

  // spare key code, behaves as arrival time
  localparam logic [1:0] KEY_SPARE = 2'd3;
  localparam logic [1:0] KEY_ORDER [4] = '{KEY_REM, KEY_PRIO, KEY_ARR, KEY_SPARE};

  typedef struct packed {
    logic                 kind;
    logic [PID_W-1:0]     pid;
    logic [TIME_IN_W-1:0] arr;
    logic [TIME_IN_W-1:0] burst;
    logic [PRIO_W-1:0]    prio;
  } job_req_t;

  typedef struct packed {
    rstat_t           status;
    logic [PID_W-1:0] pid;
    logic [NOW_W-1:0] tick;
    logic             fin;
    logic [JOBS_W-1:0] left;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_PREEMPT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic in_tuser = REQ_LOAD;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [STATUS_W-1:0] out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;

  tick_driven_job_scheduler_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Job table copy, clock and configuration kept by the predictor
  bit                   slot_used [NSLOT] = '{default: 1'b0};
  logic [PID_W-1:0]     job_pid   [NSLOT];
  logic [TIME_IN_W-1:0] job_arr   [NSLOT];
  logic [TIME_IN_W-1:0] job_rem   [NSLOT];
  logic [PRIO_W-1:0]    job_prio  [NSLOT];
  logic [NOW_W-1:0]     now_t = '0;
  int                   run_slot = 0;
  bit                   run_active = 1'b0;
  bit                   cfg_preempt = 1'b0;
  logic [1:0]           cfg_key = KEY_REM;

  job_req_t   req_q [$];
  sched_res_t sched_exp_q [$];
  int n_pushed = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_mismatch = 0;
  int idle_cycles = 0;
  int status_seen [6] = '{default: 0};
  bit gap_on = 1'b1;
  bit in_acc = 1'b0;
  bit out_acc = 1'b0;

  function automatic int held_jobs();
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++) n += slot_used[i];
    return n;
  endfunction

  function automatic int sel_key(int s);
    case (cfg_key)
      KEY_REM:  return int'(job_rem[s]);
      KEY_PRIO: return int'(job_prio[s]);
      default:  return int'(job_arr[s]);
    endcase
  endfunction

  // Applies one request to the table copy and returns the expected result
  function automatic sched_res_t sched_step(input job_req_t r);
    sched_res_t res;
    int s;
    bit found;
    res.status = RS_LOADED;
    res.pid    = '0;
    res.tick   = now_t;
    res.fin    = 1'b0;
    s = 0;
    found = 1'b0;
    if (r.kind == REQ_LOAD) begin
      for (int i = 0; i < NSLOT; i++)
        if (!found && !slot_used[i]) begin
          s = i;
          found = 1'b1;
        end
      // zero burst wins over a full table
      if (r.burst == '0) begin
        res.status = RS_ZERO;
      end else if (!found) begin
        res.status = RS_FULL;
      end else begin
        slot_used[s] = 1'b1;
        job_pid[s]   = r.pid;
        job_arr[s]   = r.arr;
        job_rem[s]   = r.burst;
        job_prio[s]  = r.prio;
      end
    end else if (held_jobs() == 0) begin
      res.status = RS_ALL_DONE;
      run_active = 1'b0;
    end else begin
      if (!cfg_preempt && run_active && slot_used[run_slot]) begin
        s = run_slot;
        found = 1'b1;
      end else begin
        // lowest key among arrived jobs, then earlier arrival, then lower slot
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_used[i] && NOW_W'(job_arr[i]) <= now_t) begin
            if (!found) begin
              found = 1'b1;
              s = i;
            end else if (sel_key(i) < sel_key(s) ||
                         (sel_key(i) == sel_key(s) && job_arr[i] < job_arr[s])) begin
              s = i;
            end
          end
        end
      end
      if (found) begin
        res.status = RS_RAN;
        res.pid    = job_pid[s];
        job_rem[s] = job_rem[s] - TIME_IN_W'(1);
        if (job_rem[s] == '0) begin
          slot_used[s] = 1'b0;
          res.fin = 1'b1;
          run_active = 1'b0;
        end else begin
          run_active = 1'b1;
          run_slot = s;
        end
      end else begin
        res.status = RS_IDLE;
        run_active = 1'b0;
      end
      if (now_t != TIME_MAX) now_t = now_t + NOW_W'(1);
    end
    res.left = JOBS_W'(held_jobs());
    return res;
  endfunction

  // Checker: results against the oldest expectation, then new predictions
  always @(posedge clk) begin
    sched_res_t e;
    job_req_t r;
    logic [1:0] pad;
    in_acc  <= in_tvalid && in_tready;
    out_acc <= out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      pad = out_tdata[47:46];
      if (sched_exp_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORT)
          $display("unexpected result: status %0d pid %02h tick %0d", out_tuser,
                   out_tdata[7:0], out_tdata[39:8]);
      end else begin
        e = sched_exp_q.pop_front();
        n_checked++;
        status_seen[int'(e.status)]++;
        if (out_tuser != e.status || out_tdata[7:0] != e.pid || out_tdata[39:8] != e.tick ||
            out_tdata[40] != e.fin || out_tdata[45:41] != e.left || pad != 2'b00) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORT)
            $display({"mismatch at %0t: exp st %0d pid %02h tick %0d fin %0b left %0d pad 0",
                      " | got st %0d pid %02h tick %0d fin %0b left %0d pad %0d"},
                     $realtime, e.status, e.pid, e.tick, e.fin, e.left, out_tuser,
                     out_tdata[7:0], out_tdata[39:8], out_tdata[40], out_tdata[45:41], pad);
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      r.kind  = in_tuser;
      r.pid   = in_tdata[7:0];
      r.arr   = in_tdata[23:8];
      r.burst = in_tdata[39:24];
      r.prio  = in_tdata[47:40];
      sched_exp_q.push_back(sched_step(r));
      n_accepted++;
    end
    // watchdog: no transaction on either side for too long
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Request driver with random gaps between transactions
  always @(negedge clk) begin
    static int in_gap = 0;
    job_req_t r;
    bit vld;
    vld = 1'b0;
    if (in_acc) in_gap = gap_on ? $urandom_range(0, 3) : 0;
    if (!rst_n) begin
      vld = 1'b0;
    end else if (in_tvalid && !in_acc) begin
      vld = 1'b1;
    end else if (in_gap > 0) begin
      in_gap--;
    end else if (req_q.size() > 0) begin
      r = req_q.pop_front();
      in_tuser <= r.kind;
      in_tdata <= {r.prio, r.burst, r.arr, r.pid};
      vld = 1'b1;
    end
    in_tvalid <= vld;
  end

  // Result receiver: random stalls plus one long hold to back up the input
  always @(negedge clk) begin
    static int out_gap = 0;
    static int hold_left = 0;
    static int n_got = 0;
    bit rdy;
    rdy = 1'b1;
    if (out_acc) begin
      n_got++;
      out_gap = gap_on ? $urandom_range(0, 3) : 0;
      if (n_got == HOLD_AFTER) hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      rdy = 1'b0;
      hold_left--;
    end else if (out_gap > 0) begin
      rdy = 1'b0;
      out_gap--;
    end
    out_tready <= rdy;
  end

  function automatic job_req_t load_req(logic [7:0] pid, logic [15:0] arr,
                                        logic [15:0] burst, logic [7:0] prio);
    job_req_t r;
    r.kind  = REQ_LOAD;
    r.pid   = pid;
    r.arr   = arr;
    r.burst = burst;
    r.prio  = prio;
    return r;
  endfunction

  function automatic job_req_t tick_req();
    job_req_t r;
    r = '0;
    r.kind = REQ_TICK;
    r.pid  = 8'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic push_req(input job_req_t r);
    req_q.push_back(r);
    n_pushed++;
  endtask

  task automatic write_cfg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_PREEMPT)
      cfg_preempt = val[0];
    else
      cfg_key = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Block until every request is taken and every result checked, then settle
  task automatic wait_drained();
    do @(negedge clk); while (n_accepted != n_pushed || sched_exp_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Random mix of loads and ticks; arrivals cluster around the current tick
  task automatic random_phase(input int n, input int load_pct);
    int gen_now;
    int roll;
    logic [15:0] arr;
    logic [15:0] burst;
    logic [7:0] prio;
    gen_now = int'(now_t);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < load_pct) begin
        roll = $urandom_range(0, 9);
        if (roll < 7)
          arr = 16'(gen_now + $urandom_range(0, 6));
        else if (roll < 9)
          arr = 16'(gen_now - $urandom_range(0, (gen_now < 20) ? gen_now : 20));
        else
          arr = 16'(gen_now + $urandom_range(7, 30));
        roll = $urandom_range(0, 9);
        if (roll == 0)
          burst = '0;
        else if (roll < 9)
          burst = 16'($urandom_range(1, 3));
        else
          burst = 16'($urandom_range(4, 12));
        // narrow priorities give plenty of key ties
        prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        push_req(load_req(8'($urandom_range(0, 255)), arr, burst, prio));
      end else begin
        push_req(tick_req());
        gen_now++;
      end
    end
  endtask

  initial begin
    int pct;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, zero burst, waiting for arrival, fill and overflow
    write_cfg(CFG_PREEMPT, 2'd0);
    write_cfg(CFG_KEY, KEY_REM);
    gap_on = 1'b1;
    push_req(tick_req());
    push_req(load_req(8'h00, 16'h0000, 16'h0000, 8'h00));
    push_req(load_req(8'hFF, 16'h0002, 16'h0002, 8'hFF));
    repeat (4) push_req(tick_req());
    push_req(tick_req());
    for (int i = 0; i < NSLOT; i++)
      push_req(load_req(8'(8'h10 + i), 16'h0000, 16'((i % 3) + 1), 8'((i * 37) % 256)));
    push_req(load_req(8'h5A, 16'h0001, 16'h0004, 8'h01));
    push_req(load_req(8'hA5, 16'h0001, 16'h0000, 8'h01));
    wait_drained();

    // Both scheduling modes against every key code; mode flips mid-job
    for (int ph = 1; ph <= 8; ph++) begin
      write_cfg(CFG_PREEMPT, {1'b0, ph[0]});
      write_cfg(CFG_KEY, KEY_ORDER[(ph - 1) / 2]);
      gap_on = (ph % 2 == 0);
      pct = (ph % 3 == 0) ? 35 : ((ph % 3 == 1) ? 60 : 20);
      random_phase(PHASE_ITEMS, pct);
      // a job that never arrives, with every arrival and burst bit set
      if (ph == 8) push_req(load_req(8'($urandom_range(0, 255)), 16'hFFFF, 16'hFFFF,
                                     8'($urandom_range(0, 255))));
      wait_drained();
    end

    $display({"Run covered %0d requests and %0d checked results over run-to-completion",
              " and preemptive modes with all four key codes"},
             n_accepted, n_checked);
    $display("Statuses: loaded %0d, full %0d, zero burst %0d, ran %0d, idle %0d, all done %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (n_mismatch == 0 && sched_exp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results outstanding", n_mismatch, sched_exp_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/tdjs_pkg.sv
rtl/tdjs_ctrl.sv
rtl/tdjs_dp.sv
rtl/tick_driven_job_scheduler_core.sv
sim/tb_tick_driven_job_scheduler_core.sv
